>>> design/mh_pkg.sv
// Shared types and constants of the magnetometer heading core.
package mh_pkg;

    // Number of CORDIC cells in the chain.
    localparam int N_STEPS = 23;

    // Inputs are scaled by 2^24 before the rotations.
    localparam int PRESCALE_BITS = 24;

    // Widths of the rotation datapath and the angle accumulator.
    localparam int CORD_W = 42;
    localparam int ANG_W  = 25;
    localparam int QANG_W = 23;
    localparam int ATAN_W = 22;

    // Angles in units of 2^-16 degree.
    localparam logic [QANG_W-1:0] ANG_90  = 23'd5898240;
    localparam logic [ANG_W-1:0]  ANG_180 = 25'd11796480;
    localparam logic [ANG_W-1:0]  ANG_360 = 25'd23592960;

    // atan(2^-i) in units of 2^-16 degree.
    localparam logic [ATAN_W-1:0] ATAN_TAB [N_STEPS] = '{
        22'd2949120, 22'd1740967, 22'd919879, 22'd466945, 22'd234379, 22'd117304,
        22'd58666,   22'd29335,   22'd14668,  22'd7334,   22'd3667,   22'd1833,
        22'd917,     22'd458,     22'd229,    22'd115,    22'd57,     22'd29,
        22'd14,      22'd7,       22'd4,      22'd2,      22'd1
    };

    // Payload handed from cell to cell.
    typedef struct packed {
        logic signed [15:0]       xv;
        logic signed [15:0]       yv;
        logic signed [15:0]       zv;
        logic signed [CORD_W-1:0] cx;
        logic signed [CORD_W-1:0] cy;
        logic signed [ANG_W-1:0]  cz;
    } t_cell_data;

endpackage

>>> design/mh_stream_if.sv
// Handshake interfaces for the sample and result channels.
interface mh_sample_if;
    logic       valid;
    logic       ready;
    logic [7:0] x_low;
    logic [7:0] x_high;
    logic [7:0] y_low;
    logic [7:0] y_high;
    logic [7:0] z_low;
    logic [7:0] z_high;

    modport source (output valid, x_low, x_high, y_low, y_high, z_low, z_high,
                    input ready);
    modport sink   (input valid, x_low, x_high, y_low, y_high, z_low, z_high,
                    output ready);
endinterface

interface mh_result_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] x_value;
    logic signed [15:0] y_value;
    logic signed [15:0] z_value;
    logic [15:0]        heading;

    modport source (output valid, x_value, y_value, z_value, heading, input ready);
    modport sink   (input valid, x_value, y_value, z_value, heading, output ready);
endinterface

>>> design/mh_cordic_cell.sv
// One CORDIC vectoring cell with its own valid bit and payload register.
module mh_cordic_cell #(
    parameter int STEP = 0
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  mh_pkg::t_cell_data i_data,
    output logic               o_valid,
    input  logic               i_ready,
    output mh_pkg::t_cell_data o_data
);

    localparam logic signed [mh_pkg::ANG_W-1:0] ATAN_STEP =
        mh_pkg::ANG_W'(mh_pkg::ATAN_TAB[STEP]);

    logic               r_valid;
    mh_pkg::t_cell_data r_data;
    mh_pkg::t_cell_data n_data;

    logic signed [mh_pkg::CORD_W-1:0] mag_x;
    logic signed [mh_pkg::CORD_W-1:0] mag_y;
    logic signed [mh_pkg::CORD_W-1:0] dx;
    logic signed [mh_pkg::CORD_W-1:0] dy;

    // Shifts truncate toward zero, so the magnitude is shifted and the sign restored.
    always_comb begin
        mag_y = i_data.cy[mh_pkg::CORD_W-1] ? -i_data.cy : i_data.cy;
        mag_x = i_data.cx[mh_pkg::CORD_W-1] ? -i_data.cx : i_data.cx;
        dx    = i_data.cy[mh_pkg::CORD_W-1] ? -(mag_y >> STEP) : (mag_y >> STEP);
        dy    = i_data.cx[mh_pkg::CORD_W-1] ? -(mag_x >> STEP) : (mag_x >> STEP);

        n_data = i_data;
        if (i_data.cy > 0) begin
            n_data.cx = i_data.cx + dx;
            n_data.cy = i_data.cy - dy;
            n_data.cz = i_data.cz + ATAN_STEP;
        end else begin
            n_data.cx = i_data.cx - dx;
            n_data.cy = i_data.cy + dy;
            n_data.cz = i_data.cz - ATAN_STEP;
        end
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

>>> design/mh_heading_stage.sv
// Final stage: clamps the angle, restores the quadrant, rounds and registers the result.
module mh_heading_stage #(
    parameter int HEADING_FRAC_BITS = 7
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  mh_pkg::t_cell_data i_data,
    mh_result_if.source        o_result
);

    localparam int SHIFT = 16 - HEADING_FRAC_BITS;
    localparam logic [mh_pkg::ANG_W-1:0] HALF  = mh_pkg::ANG_W'(1 << (SHIFT - 1));
    localparam logic [mh_pkg::ANG_W-1:0] LIMIT = mh_pkg::ANG_W'(360 << HEADING_FRAC_BITS);

    localparam logic signed [mh_pkg::ANG_W-1:0] ANG_90_S =
        $signed({2'b00, mh_pkg::ANG_90});

    logic                       r_valid;
    logic signed [15:0]         r_x_value;
    logic signed [15:0]         r_y_value;
    logic signed [15:0]         r_z_value;
    logic [15:0]                r_heading;
    logic [15:0]                n_heading;

    logic [mh_pkg::QANG_W-1:0]  quad_ang;
    logic [mh_pkg::ANG_W-1:0]   full_ang;
    logic [mh_pkg::ANG_W-1:0]   rounded;
    logic [mh_pkg::ANG_W-1:0]   scaled;

    always_comb begin
        priority if (i_data.cz < 0) begin
            quad_ang = '0;
        end else if (i_data.cz > ANG_90_S) begin
            quad_ang = mh_pkg::ANG_90;
        end else begin
            quad_ang = i_data.cz[mh_pkg::QANG_W-1:0];
        end

        priority if (!i_data.xv[15] && !i_data.yv[15]) begin
            full_ang = {2'b00, quad_ang};
        end else if (i_data.xv[15] && !i_data.yv[15]) begin
            full_ang = mh_pkg::ANG_180 - {2'b00, quad_ang};
        end else if (i_data.xv[15]) begin
            full_ang = mh_pkg::ANG_180 + {2'b00, quad_ang};
        end else begin
            full_ang = mh_pkg::ANG_360 - {2'b00, quad_ang};
        end

        rounded = full_ang + HALF;
        scaled  = rounded >> SHIFT;
        if (scaled >= LIMIT) begin
            scaled = LIMIT - 1'b1;
        end
        n_heading = scaled[15:0];
    end

    assign o_ready = !r_valid || o_result.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_x_value <= i_data.xv;
            r_y_value <= i_data.yv;
            r_z_value <= i_data.zv;
            r_heading <= n_heading;
        end
    end

    assign o_result.valid   = r_valid;
    assign o_result.x_value = r_x_value;
    assign o_result.y_value = r_y_value;
    assign o_result.z_value = r_z_value;
    assign o_result.heading = r_heading;

endmodule

>>> design/magnetometer_heading_core.sv
// Top level of the magnetometer heading core: sample prep, CORDIC cell chain, heading stage.
//
//   channel    direction  carries                              handshake
//   i_sample   in         x/y/z low and high raw bytes         valid/ready
//   o_result   out        x/y/z signed words, heading          valid/ready
//
// An accepted sample passes through one prep stage, 23 CORDIC cells (one rotation
// each) and one heading stage before its result appears.
// Throughput is one item per cycle while results are taken; every stage holds a valid bit of its own.
// A stage takes a new item whenever it is empty or its neighbor takes its item,
// so a held result stalls only the full stages behind it and bubbles close up.
// Reset (synchronous, active low) clears the valid bits; the pipe then holds no item.
module magnetometer_heading_core #(
    parameter int HEADING_FRAC_BITS = 7
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mh_sample_if.sink   i_sample,
    mh_result_if.source o_result
);

    // Valid, ready and payload at each link of the chain. Link 0 is the prep stage
    // output; link N_STEPS is the last cell output feeding the heading stage.
    logic               link_valid [mh_pkg::N_STEPS+1];
    logic               link_ready [mh_pkg::N_STEPS+1];
    mh_pkg::t_cell_data link_data  [mh_pkg::N_STEPS+1];

    // Prep stage: assemble the signed words and load the scaled magnitudes.
    logic               r_prep_valid;
    mh_pkg::t_cell_data r_prep_data;
    mh_pkg::t_cell_data n_prep_data;
    logic               prep_ready;

    logic signed [15:0] x_word;
    logic signed [15:0] y_word;
    logic signed [15:0] z_word;
    logic [16:0]        x_mag;
    logic [16:0]        y_mag;

    always_comb begin
        x_word = $signed({i_sample.x_high, i_sample.x_low});
        y_word = $signed({i_sample.y_high, i_sample.y_low});
        z_word = $signed({i_sample.z_high, i_sample.z_low});

        // Magnitudes take 17 bits so that the most negative word survives.
        x_mag = x_word[15] ? (17'd0 - {x_word[15], x_word}) : {1'b0, x_word};
        y_mag = y_word[15] ? (17'd0 - {y_word[15], y_word}) : {1'b0, y_word};

        n_prep_data.xv = x_word;
        n_prep_data.yv = y_word;
        n_prep_data.zv = z_word;
        n_prep_data.cx = $signed({1'b0, x_mag, {mh_pkg::PRESCALE_BITS{1'b0}}});
        n_prep_data.cy = $signed({1'b0, y_mag, {mh_pkg::PRESCALE_BITS{1'b0}}});
        n_prep_data.cz = '0;
    end

    assign prep_ready     = !r_prep_valid || link_ready[0];
    assign i_sample.ready = prep_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prep_valid <= 1'b0;
        end else if (prep_ready) begin
            r_prep_valid <= i_sample.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (prep_ready && i_sample.valid) begin
            r_prep_data <= n_prep_data;
        end
    end

    assign link_valid[0] = r_prep_valid;
    assign link_data[0]  = r_prep_data;

    // The rotation chain: cell k applies the rotation by atan(2^-k).
    for (genvar k = 0; k < mh_pkg::N_STEPS; k++) begin : g_cell
        mh_cordic_cell #(
            .STEP (k)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (link_valid[k]),
            .o_ready (link_ready[k]),
            .i_data  (link_data[k]),
            .o_valid (link_valid[k+1]),
            .i_ready (link_ready[k+1]),
            .o_data  (link_data[k+1])
        );
    end

    // Quadrant restore, rounding to the output fraction and the result register.
    mh_heading_stage #(
        .HEADING_FRAC_BITS (HEADING_FRAC_BITS)
    ) u_heading (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (link_valid[mh_pkg::N_STEPS]),
        .o_ready  (link_ready[mh_pkg::N_STEPS]),
        .i_data   (link_data[mh_pkg::N_STEPS]),
        .o_result (o_result)
    );

endmodule

>>> tb/testbench.sv
// Self-checking testbench of the magnetometer heading core: randomized stream, predicted results.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD   = 20;
    localparam int HFRAC        = 7;
    localparam int PIPE_LATENCY = 25;
    localparam int RANDOM_ITEMS = 750;
    localparam int STALL_AT     = 120;
    localparam int STALL_CYCLES = 300;
    localparam int IDLE_LIMIT   = 2000;

    typedef struct {
        logic [7:0] x_low;
        logic [7:0] x_high;
        logic [7:0] y_low;
        logic [7:0] y_high;
        logic [7:0] z_low;
        logic [7:0] z_high;
    } t_raw_sample;

    typedef struct {
        logic signed [15:0] x_value;
        logic signed [15:0] y_value;
        logic signed [15:0] z_value;
        logic [15:0]        heading;
    } t_reading;

    logic i_clk = 1'b0;
    logic i_rst_n;

    mh_sample_if sample_ch ();
    mh_result_if result_ch ();

    magnetometer_heading_core #(
        .HEADING_FRAC_BITS(HFRAC)
    ) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sample(sample_ch),
        .o_result(result_ch)
    );

    t_raw_sample pending_samples[$];
    t_reading    expected_readings[$];
    int          error_count = 0;
    bit          sample_taken = 1'b0;
    bit          result_taken = 1'b0;

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // atan(2^-i) in 2^-16 degree
    const longint ARCTAN_STEPS[23] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115,
        57, 29, 14, 7, 4, 2, 1
    };

    // Shift toward zero, as the rotation cells do on negative values.
    function automatic longint shift_toward_zero(longint v, int s);
        if (v >= 0) begin
            return v >>> s;
        end
        return -((-v) >>> s);
    endfunction

    // Bearing atan2(y, x) in 2^-HFRAC degree, from an integer CORDIC in 2^-16 degree.
    function automatic logic [15:0] bearing_of(logic signed [15:0] xv, logic signed [15:0] yv);
        longint ax, ay, cx, cy, cz, dx, dy, full, h, limit;
        if (xv == 0 && yv == 0) begin
            return 16'd0;
        end
        ax = (xv < 0) ? -longint'(xv) : longint'(xv);
        ay = (yv < 0) ? -longint'(yv) : longint'(yv);
        cx = ax * 64'sd16777216;
        cy = ay * 64'sd16777216;
        cz = 0;
        for (int i = 0; i < 23; i++) begin
            dx = shift_toward_zero(cy, i);
            dy = shift_toward_zero(cx, i);
            if (cy > 0) begin
                cx += dx;
                cy -= dy;
                cz += ARCTAN_STEPS[i];
            end else begin
                cx -= dx;
                cy += dy;
                cz -= ARCTAN_STEPS[i];
            end
        end
        if (cz < 0) cz = 0;
        if (cz > 90 * 65536) cz = 90 * 65536;
        if (xv >= 0 && yv >= 0) full = cz;
        else if (xv < 0 && yv >= 0) full = 180 * 65536 - cz;
        else if (xv < 0) full = 180 * 65536 + cz;
        else full = 360 * 65536 - cz;
        h = (full + (longint'(1) << (15 - HFRAC))) >>> (16 - HFRAC);
        limit = longint'(360) << HFRAC;
        if (h >= limit) h = limit - 1;
        return h[15:0];
    endfunction

    function automatic t_reading predict_reading(t_raw_sample s);
        t_reading r;
        r.x_value = {s.x_high, s.x_low};
        r.y_value = {s.y_high, s.y_low};
        r.z_value = {s.z_high, s.z_low};
        r.heading = bearing_of(r.x_value, r.y_value);
        return r;
    endfunction

    task automatic queue_sample(logic [15:0] x, logic [15:0] y, logic [15:0] z);
        t_raw_sample s;
        s.x_low  = x[7:0];
        s.x_high = x[15:8];
        s.y_low  = y[7:0];
        s.y_high = y[15:8];
        s.z_low  = z[7:0];
        s.z_high = z[15:8];
        pending_samples.push_back(s);
    endtask

    // One random axis word; the mix favors small values, axes and extremes.
    function automatic logic [15:0] pick_word(int mode);
        logic [15:0] extremes[5] = '{16'h8000, 16'h7FFF, 16'h0000, 16'h0001, 16'hFFFF};
        case (mode)
            0, 1, 2, 3: return 16'($urandom);
            4, 5:       return 16'($urandom_range(0, 64) - 32);
            6:          return extremes[$urandom_range(0, 4)];
            default:    return 16'($urandom_range(0, 2000) - 1000);
        endcase
    endfunction

    function automatic int draw_wait(bit calm);
        return calm ? 0 : int'($urandom_range(0, 4));
    endfunction

    // Sender: presents queued items, with a random gap drawn before each one.
    int sent_count = 0;
    int send_gap = 0;
    always @(negedge i_clk) begin
        t_raw_sample s;
        if (i_rst_n) begin
            if (!sample_ch.valid || sample_taken) begin
                if (sample_taken) begin
                    sent_count++;
                    send_gap = draw_wait((sent_count / 70) % 4 == 3);
                end
                if (send_gap == 0 && pending_samples.size() > 0) begin
                    s = pending_samples.pop_front();
                    sample_ch.x_low  <= s.x_low;
                    sample_ch.x_high <= s.x_high;
                    sample_ch.y_low  <= s.y_low;
                    sample_ch.y_high <= s.y_high;
                    sample_ch.z_low  <= s.z_low;
                    sample_ch.z_high <= s.z_high;
                    sample_ch.valid  <= 1'b1;
                end else begin
                    if (send_gap > 0) send_gap--;
                    sample_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: random hold-off per item, plus one long stall so the pipe backs up.
    int results_seen = 0;
    int recv_hold = 0;
    int long_stall = 0;
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (result_taken) begin
                results_seen++;
                recv_hold = draw_wait((results_seen / 60) % 3 == 1);
                if (results_seen == STALL_AT) long_stall = STALL_CYCLES;
            end
            if (long_stall > 0) begin
                long_stall--;
                result_ch.ready <= 1'b0;
            end else if (recv_hold > 0) begin
                recv_hold--;
                result_ch.ready <= 1'b0;
            end else begin
                result_ch.ready <= 1'b1;
            end
        end
    end

    task automatic check_field(string name, int expected, int actual);
        if (expected != actual) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, expected, actual);
            error_count++;
        end
    endtask

    // Monitor: records accepted samples as expectations and checks accepted results.
    always @(posedge i_clk) begin
        t_raw_sample s;
        t_reading    want;
        sample_taken <= sample_ch.valid && sample_ch.ready;
        result_taken <= result_ch.valid && result_ch.ready;
        if (i_rst_n) begin
            if (sample_ch.valid && sample_ch.ready) begin
                s.x_low  = sample_ch.x_low;
                s.x_high = sample_ch.x_high;
                s.y_low  = sample_ch.y_low;
                s.y_high = sample_ch.y_high;
                s.z_low  = sample_ch.z_low;
                s.z_high = sample_ch.z_high;
                expected_readings.push_back(predict_reading(s));
            end
            if (result_ch.valid && result_ch.ready) begin
                if (expected_readings.size() == 0) begin
                    $display("%0t: unexpected result, expected none, got heading %0d",
                             $time, result_ch.heading);
                    error_count++;
                end else begin
                    want = expected_readings.pop_front();
                    check_field("x_value", want.x_value, result_ch.x_value);
                    check_field("y_value", want.y_value, result_ch.y_value);
                    check_field("z_value", want.z_value, result_ch.z_value);
                    check_field("heading", want.heading, result_ch.heading);
                end
            end
        end
    end

    // Watchdog on cycles with no handshake on either side.
    int idle_cycles = 0;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("%0t: watchdog expired with %0d results outstanding",
                         $time, expected_readings.size());
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    initial begin
        int mode;
        i_rst_n          = 1'b0;
        sample_ch.valid  = 1'b0;
        sample_ch.x_low  = 8'h00;
        sample_ch.x_high = 8'h00;
        sample_ch.y_low  = 8'h00;
        sample_ch.y_high = 8'h00;
        sample_ch.z_low  = 8'h00;
        sample_ch.z_high = 8'h00;
        result_ch.ready  = 1'b0;

        // Directed samples: both axes zero, extremes, each quadrant, the axes,
        // and a bearing just below 360 that rounds up and must saturate.
        queue_sample(16'h0000, 16'h0000, 16'h0000);
        queue_sample(16'hFFFF, 16'hFFFF, 16'hFFFF);
        queue_sample(16'h8000, 16'h8000, 16'h8000);
        queue_sample(16'h7FFF, 16'h7FFF, 16'h7FFF);
        queue_sample(16'h7FFF, 16'h8000, 16'h0000);
        queue_sample(16'h8000, 16'h7FFF, 16'h00FF);
        queue_sample(16'h0001, 16'h0000, 16'hFF00);
        queue_sample(16'h0000, 16'h0001, 16'h0080);
        queue_sample(16'h8000, 16'h0000, 16'h8080);
        queue_sample(16'h0000, 16'h8000, 16'h7F7F);
        queue_sample(16'hFFFF, 16'h0000, 16'h0001);
        queue_sample(16'h0000, 16'hFFFF, 16'hFFFE);
        queue_sample(16'd100, 16'd100, 16'd5);
        queue_sample(-16'sd100, 16'd100, 16'd6);
        queue_sample(-16'sd100, -16'sd100, 16'd7);
        queue_sample(16'd100, -16'sd100, 16'd8);
        queue_sample(16'h7FFF, 16'hFFFF, 16'h1234);
        queue_sample(16'h7FFF, 16'h0001, 16'h4321);
        queue_sample(16'h8000, 16'hFFFF, 16'hAAAA);
        queue_sample(16'h8000, 16'h0001, 16'h5555);
        queue_sample(16'h00FF, 16'h0080, 16'h80FF);
        queue_sample(16'hFF80, 16'h00FF, 16'hFF7F);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            mode = $urandom_range(0, 9);
            if (mode == 9) begin
                // Near the positive X axis from below, where the bearing nears 360.
                queue_sample(16'($urandom_range(20000, 32767)), 16'(-$urandom_range(1, 8)),
                             16'($urandom));
            end else if (mode == 8) begin
                // Points on the X axis and on the Y axis, with a random signed value on each.
                queue_sample(pick_word(4), 16'h0000, 16'($urandom));
                queue_sample(16'h0000, pick_word(0), 16'($urandom));
            end else begin
                queue_sample(pick_word(mode), pick_word($urandom_range(0, 7)),
                             16'($urandom));
            end
        end

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_samples.size() > 0 || sample_ch.valid) @(posedge i_clk);
        while (expected_readings.size() > 0) @(posedge i_clk);
        repeat (2 * PIPE_LATENCY) @(posedge i_clk);

        if (error_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

>>> sim.f
design/mh_pkg.sv
design/mh_stream_if.sv
design/mh_cordic_cell.sv
design/mh_heading_stage.sv
design/magnetometer_heading_core.sv
tb/testbench.sv
